[rtl/core/arslu_pkg.sv]
// Shared types and codes for the address range symbol lookup block.
// Holds the request, entry and result structures and the kind and status codes.
// Depends on nothing; every module of the block imports it.
package arslu_pkg;

    localparam int AddrWidth = 64;
    localparam int LenWidth  = 32;
    localparam int SymWidth  = 16;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_REJECTED  = 2'd3;

    typedef struct packed {
        logic [SymWidth-1:0]  symbol;
        logic [LenWidth-1:0]  length;
        logic [AddrWidth-1:0] start;
    } t_entry;

    typedef struct packed {
        logic [AddrWidth-1:0] query;
        t_entry               entry;
        logic [1:0]           kind;
    } t_request;

    typedef struct packed {
        logic [LenWidth-1:0] offset;
        logic [SymWidth-1:0] symbol;
        logic [1:0]          status;
    } t_result;

endpackage

[rtl/core/arslu_engine.sv]
// Table memory and the sequencer that inserts, clears and searches it.
// Depends on arslu_pkg for the request, entry and result structures.
// The entry memory has one write port and one registered read port.
module arslu_engine #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  arslu_pkg::t_request i_req,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output arslu_pkg::t_result o_res
);
    import arslu_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_INS_RD  = 7'b0000010,
        S_INS_CMP = 7'b0000100,
        S_INS_PUT = 7'b0001000,
        S_LK_RD   = 7'b0010000,
        S_LK_CMP  = 7'b0100000,
        S_RESP    = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_lo, n_lo;
    logic [CW-1:0]         r_hi, n_hi;
    logic [IW-1:0]         r_mid, n_mid;
    t_entry                r_ent, n_ent;
    logic [AddrWidth-1:0]  r_query, n_query;
    t_result               r_res, n_res;

    t_entry                mem [TABLE_DEPTH];
    t_entry                r_rd_data;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    t_entry                wr_data;

    logic [CW:0]           mid_sum;
    logic [CW-1:0]         pos_dec;
    logic [AddrWidth-1:0]  diff;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_ent   = r_ent;
        n_query = r_query;
        n_res   = r_res;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_pos[IW-1:0];
        wr_data = r_ent;
        mid_sum = {1'b0, r_lo} + {1'b0, r_hi} - (CW+1)'(1);
        pos_dec = r_pos - CW'(1);
        diff    = r_query - r_rd_data.start;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_ent   = i_req.entry;
                    n_query = i_req.query;
                    n_res   = '0;
                    n_state = S_RESP;
                    unique case (i_req.kind)
                        KIND_CLEAR: begin
                            n_count    = '0;
                            n_res.status = ST_OK;
                        end
                        KIND_INSERT: begin
                            if (i_req.entry.start == '0 || i_req.entry.length == '0) begin
                                n_res.status = ST_REJECTED;
                            end else if (r_count == CW'(TABLE_DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else if (r_count == '0) begin
                                wr_en        = 1'b1;
                                wr_addr      = '0;
                                wr_data      = i_req.entry;
                                n_count      = r_count + CW'(1);
                                n_res.status = ST_OK;
                            end else begin
                                n_pos   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        KIND_LOOKUP: begin
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_state = S_LK_RD;
                        end
                        default: begin
                            n_res.status = ST_REJECTED;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                rd_en   = 1'b1;
                rd_addr = pos_dec[IW-1:0];
                n_state = S_INS_CMP;
            end
            S_INS_CMP: begin
                wr_en = 1'b1;
                if (r_rd_data.start > r_ent.start) begin
                    wr_data = r_rd_data;
                    n_pos   = pos_dec;
                    n_state = (pos_dec == '0) ? S_INS_PUT : S_INS_RD;
                end else begin
                    n_count      = r_count + CW'(1);
                    n_res.status = ST_OK;
                    n_state      = S_RESP;
                end
            end
            S_INS_PUT: begin
                wr_en        = 1'b1;
                n_count      = r_count + CW'(1);
                n_res.status = ST_OK;
                n_state      = S_RESP;
            end
            S_LK_RD: begin
                if (r_lo >= r_hi) begin
                    n_res.status = ST_NOT_FOUND;
                    n_state      = S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = mid_sum[IW:1];
                    n_mid   = mid_sum[IW:1];
                    n_state = S_LK_CMP;
                end
            end
            S_LK_CMP: begin
                n_state = S_LK_RD;
                if (r_query < r_rd_data.start) begin
                    n_hi = CW'(r_mid);
                end else if (diff[AddrWidth-1:LenWidth] != '0 ||
                             diff[LenWidth-1:0] >= r_rd_data.length) begin
                    n_lo = CW'(r_mid) + CW'(1);
                end else begin
                    n_res.status = ST_OK;
                    n_res.symbol = r_rd_data.symbol;
                    n_res.offset = diff[LenWidth-1:0];
                    n_state      = S_RESP;
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos   <= n_pos;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_ent   <= n_ent;
        r_query <= n_query;
        r_res   <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;

endmodule

[rtl/core/address_range_symbol_lookup_top.sv]
// Top level of the address range symbol lookup block.
// Instantiates arslu_engine and holds the output register; uses arslu_pkg.
//
// The block keeps up to TABLE_DEPTH ranges sorted by start address in one memory
// and handles one request at a time, each giving exactly one result. A clear, a
// rejected insert or an insert into a full or an empty table goes straight from the
// idle state to the response state. Any other insert moves every stored entry whose
// start exceeds the new one up one place at a time through the single read port,
// then writes the new range. A lookup runs a binary search over the filled
// entries, each probe a registered memory read followed by a compare.
// A new request is taken while the previous result still waits on the output.
module address_range_symbol_lookup_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // range_start [63:0], range_length [95:64], symbol_id [111:96],
    // query_address [175:112]
    input  logic [175:0] s_tdata,
    // kind [1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found_symbol [15:0], match_offset [47:16]
    output logic [47:0]  m_tdata,
    // status [1:0]
    output logic [1:0]   m_tuser
);
    import arslu_pkg::*;

    t_request req;
    t_result  res;
    logic     res_valid;
    logic     res_ready;
    logic     r_out_valid;
    t_result  r_out;

    assign req.kind         = s_tuser;
    assign req.entry.start  = s_tdata[63:0];
    assign req.entry.length = s_tdata[95:64];
    assign req.entry.symbol = s_tdata[111:96];
    assign req.query        = s_tdata[175:112];

    arslu_engine #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .o_req_ready (s_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out.offset, r_out.symbol};
    assign m_tuser  = r_out.status;

endmodule

[dv/lookup_checker.sv]
`timescale 1ns / 100ps
// Checker for the address range symbol lookup block: watches both stream channels,
// keeps its own copy of the range table to predict every result and compares them.
// Depends on arslu_pkg for the request, result and code definitions.
module lookup_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // range_start [63:0], range_length [95:64], symbol_id [111:96],
    // query_address [175:112]
    input  logic [175:0] s_tdata,
    // kind [1:0]
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // found_symbol [15:0], match_offset [47:16]
    input  logic [47:0]  m_tdata,
    // status [1:0]
    input  logic [1:0]   m_tuser,
    output int           o_fail_count,
    output int           o_pending
);
    import arslu_pkg::*;

    logic [AddrWidth-1:0] shadow_starts  [TABLE_DEPTH];
    logic [LenWidth-1:0]  shadow_lengths [TABLE_DEPTH];
    logic [SymWidth-1:0]  shadow_symbols [TABLE_DEPTH];
    int                   shadow_count = 0;
    t_result              awaited_answers[$];
    int                   mismatches = 0;

    function automatic t_result resolve_request(input t_request req);
        t_result              res;
        int                   lo;
        int                   hi;
        int                   mid;
        int                   pos;
        logic [AddrWidth-1:0] gap;
        res = '0;
        case (req.kind)
            KIND_CLEAR: begin
                shadow_count = 0;
                res.status = ST_OK;
            end
            KIND_INSERT: begin
                if (req.entry.start == '0 || req.entry.length == '0) begin
                    res.status = ST_REJECTED;
                end else if (shadow_count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // Later ranges with an equal start go behind the earlier ones.
                    pos = shadow_count;
                    while (pos > 0 && shadow_starts[pos-1] > req.entry.start) begin
                        shadow_starts[pos]  = shadow_starts[pos-1];
                        shadow_lengths[pos] = shadow_lengths[pos-1];
                        shadow_symbols[pos] = shadow_symbols[pos-1];
                        pos--;
                    end
                    shadow_starts[pos]  = req.entry.start;
                    shadow_lengths[pos] = req.entry.length;
                    shadow_symbols[pos] = req.entry.symbol;
                    shadow_count++;
                    res.status = ST_OK;
                end
            end
            KIND_LOOKUP: begin
                res.status = ST_NOT_FOUND;
                lo = 0;
                hi = shadow_count - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (req.query < shadow_starts[mid]) begin
                        hi = mid - 1;
                    end else begin
                        gap = req.query - shadow_starts[mid];
                        if (gap >= {{(AddrWidth-LenWidth){1'b0}}, shadow_lengths[mid]}) begin
                            lo = mid + 1;
                        end else begin
                            res.status = ST_OK;
                            res.symbol = shadow_symbols[mid];
                            res.offset = gap[LenWidth-1:0];
                            lo = hi + 1;
                        end
                    end
                end
            end
            default: begin
                res.status = ST_REJECTED;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            awaited_answers.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_answers.push_back(resolve_request(t_request'({s_tdata, s_tuser})));
            end
            if (m_tvalid && m_tready) begin
                got = t_result'({m_tdata, m_tuser});
                if (awaited_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result with no request outstanding: %s %0d %0h %0h",
                                 $realtime, "status symbol offset",
                                 got.status, got.symbol, got.offset);
                    end
                end else begin
                    want = awaited_answers.pop_front();
                    if (got.status !== want.status || got.symbol !== want.symbol
                        || got.offset !== want.offset) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch: expected status %0d symbol %0h offset %0h,",
                                     $realtime, want.status, want.symbol, want.offset);
                            $display("    got status %0d symbol %0h offset %0h",
                                     got.status, got.symbol, got.offset);
                        end
                    end
                end
            end
        end
        o_fail_count = mismatches;
        o_pending = awaited_answers.size();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top of the testbench for address_range_symbol_lookup_top: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict. Uses lookup_checker and arslu_pkg.
module testbench;
    import arslu_pkg::*;

    localparam int         TABLE_DEPTH = 1024;
    localparam int         ITEM_TARGET = 1800;
    localparam int         STALL_LIMIT = 20000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic [1:0]   m_tuser;

    int           fail_count;
    int           pending_results;
    bit           calm = 1'b0;
    int           requests_sent = 0;
    int           quiet_cycles = 0;
    int           table_fill = 0;
    logic [63:0]  placed_starts[$];
    logic [31:0]  placed_lengths[$];

    address_range_symbol_lookup_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lookup_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_tready = calm || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles.", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [63:0] start,
                                input logic [31:0] length, input logic [15:0] symbol,
                                input logic [63:0] query);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 7) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = {query, symbol, length, start};
        do @(posedge i_clk); while (!s_tready);
        requests_sent++;
        if (kind == KIND_CLEAR) begin
            table_fill = 0;
            placed_starts.delete();
            placed_lengths.delete();
        end else if (kind == KIND_INSERT && start != '0 && length != '0
                     && table_fill < TABLE_DEPTH) begin
            table_fill++;
            placed_starts.push_back(start);
            placed_lengths.push_back(length);
        end
    endtask

    task automatic clear_table();
        send_request(KIND_CLEAR, rand64(), $urandom, rand16(), rand64());
    endtask

    task automatic insert_range(input logic [63:0] start, input logic [31:0] length,
                                input logic [15:0] symbol);
        send_request(KIND_INSERT, start, length, symbol, rand64());
    endtask

    task automatic look_up(input logic [63:0] addr);
        send_request(KIND_LOOKUP, rand64(), $urandom, rand16(), addr);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_results != 0) @(negedge i_clk);
    endtask

    // Lookups mostly land inside or at the edges of stored ranges.
    function automatic logic [63:0] pick_query();
        int          idx;
        int          roll;
        logic [63:0] s;
        logic [31:0] l;
        logic [63:0] addr;
        if (placed_starts.size() == 0) begin
            return rand64();
        end
        idx = $urandom_range(0, placed_starts.size() - 1);
        s = placed_starts[idx];
        l = placed_lengths[idx];
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            addr = s + ($urandom % l);
            if (addr < s) addr = '1;
        end else if (roll < 70) begin
            addr = s + l - 1;
        end else if (roll < 80) begin
            addr = s + l;
        end else if (roll < 85) begin
            addr = s - 1;
        end else begin
            addr = rand64();
        end
        return addr;
    endfunction

    task automatic insert_random_range(input logic [63:0] cluster_base);
        int roll;
        int idx;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            insert_range(cluster_base + $urandom_range(0, 4096), $urandom_range(1, 3000),
                         rand16());
        end else if (roll < 65) begin
            insert_range(rand64(), $urandom_range(1, 65536), rand16());
        end else if (roll < 85) begin
            insert_range(rand64(), $urandom, rand16());
        end else if (roll < 90) begin
            insert_range('0, $urandom, rand16());
        end else if (roll < 95) begin
            insert_range(rand64(), '0, rand16());
        end else if (placed_starts.size() != 0) begin
            idx = $urandom_range(0, placed_starts.size() - 1);
            insert_range(placed_starts[idx], $urandom_range(1, 5000), rand16());
        end else begin
            insert_range(cluster_base, $urandom_range(1, 5000), rand16());
        end
    endtask

    initial begin : stimulus
        int          step;
        int          inserts;
        int          lookups;
        int          seq;
        logic [63:0] base;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        look_up(rand64());
        send_request(KIND_UNUSED, rand64(), $urandom, rand16(), rand64());
        insert_range('0, 32'd5, 16'h0001);
        insert_range(64'h1000, '0, 16'h0002);
        insert_range('0, '0, 16'h0003);
        insert_range(64'hFFFF_FFFF_FFFF_F000, '1, '1);
        insert_range(64'h1000, 32'h100, '0);
        insert_range(64'h1000, 32'h40, 16'h0011);
        insert_range(64'h1080, 32'h200, 16'h0012);
        insert_range(64'h1, 32'h1, 16'h0013);
        insert_range('1, 32'h1, 16'h5A5A);
        look_up('0);
        look_up(64'h1);
        look_up(64'h2);
        look_up(64'h1000);
        look_up(64'h103F);
        look_up(64'h10FF);
        look_up(64'h1100);
        look_up(64'h127F);
        look_up(64'h1280);
        look_up(64'hFFFF_FFFF_FFFF_EFFF);
        look_up(64'hFFFF_FFFF_FFFF_F000);
        look_up('1);
        clear_table();
        look_up(64'h1000);
        wait_for_drain();

        // Fill the table without any idling; a few low starts force long shifts.
        calm = 1'b1;
        clear_table();
        base = 64'h0000_4000_0000_0000;
        step = 0;
        while (table_fill < TABLE_DEPTH) begin
            if (step % 128 == 64) begin
                insert_range({32'b0, $urandom_range(1, 32'hFFFF_0000)},
                             $urandom_range(1, 65536), rand16());
            end else begin
                insert_range(base + step * 64'h10000 + $urandom_range(0, 4095),
                             $urandom_range(1, 32'h18000), rand16());
            end
            step++;
        end
        repeat (3) insert_range(rand64() | 64'h1, $urandom_range(1, 4096), rand16());
        insert_range('0, $urandom, rand16());
        repeat (60) look_up(pick_query());
        calm = 1'b0;

        seq = 0;
        while (requests_sent < ITEM_TARGET) begin
            clear_table();
            base = rand64();
            inserts = $urandom_range(1, 48);
            repeat (inserts) insert_random_range(base);
            lookups = $urandom_range(4, 30);
            repeat (lookups) begin
                case ($urandom_range(0, 19))
                    0: send_request(KIND_UNUSED, rand64(), $urandom, rand16(), rand64());
                    1, 2: insert_random_range(base);
                    default: look_up(pick_query());
                endcase
            end
            seq++;
            if (seq % 4 == 0) wait_for_drain();
        end

        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
